>>> src/stdf_pkg.sv
// Shared constants and types of the serial telegram deframer.
package stdf_pkg;

  localparam int BYTE_W     = 8;
  localparam int POS_W      = 6;
  localparam int LIMIT_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_RESP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REQ   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_RESP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_REQ  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIM = 3'd5;

  localparam logic [LIMIT_W-1:0] PAYLOAD_LIMIT_RST = 6'd57;

  // Request from the parser to the emitter.
  typedef struct packed {
    logic start;
    logic resp;
  } stdf_emit_t;

endpackage

>>> src/stdf_if.sv
// Channel interfaces of the deframer: received bytes in, telegram bytes out.
interface stdf_in_if import stdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              clear;
  modport source (output valid, rx_byte, clear, input ready);
  modport sink   (input valid, rx_byte, clear, output ready);
endinterface

interface stdf_out_if import stdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic [POS_W-1:0]  byte_pos;
  logic              is_response;
  logic              last;
  modport source (output valid, frame_byte, byte_pos, is_response, last, input ready);
  modport sink   (input valid, frame_byte, byte_pos, is_response, last, output ready);
endinterface

>>> src/stdf_emitter.sv
// Frame buffer memory and the sequencer that reads a finished telegram out.
module stdf_emitter import stdf_pkg::*; #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [$clog2(FRAME_DEPTH)-1:0]       wr_addr,
  input  logic [BYTE_W-1:0]                    wr_data,
  input  stdf_emit_t                           ctl,
  input  logic [$clog2(FRAME_DEPTH+1)-1:0]     count,
  output logic                                 busy,
  stdf_out_if.source                           out_ch
);

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int CW = $clog2(FRAME_DEPTH + 1);

  logic [BYTE_W-1:0] mem [FRAME_DEPTH];

  logic              active;
  logic [CW-1:0]     rd_cnt;
  logic [CW-1:0]     n_total;
  logic              resp_frame;
  logic              resp_q;
  logic              out_valid;
  logic [BYTE_W-1:0] rdata;
  logic [POS_W-1:0]  pos_q;
  logic              last_q;
  logic              issue;
  logic              final_rd;

  // The read data register doubles as the output register, so a read is
  // issued only when the output slot is empty or being taken.
  assign issue    = active && (!out_valid || out_ch.ready);
  assign final_rd = (CW'(rd_cnt + 1'b1) == n_total);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata <= mem[rd_cnt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.start) begin
        active <= 1'b1;
      end else if (issue && final_rd) begin
        active <= 1'b0;
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The response flag travels with each beat, since a new telegram can be
  // released while the last beat of the previous one still waits.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rd_cnt     <= '0;
      n_total    <= count;
      resp_frame <= ctl.resp;
    end else if (issue) begin
      rd_cnt <= CW'(rd_cnt + 1'b1);
    end
    if (issue) begin
      pos_q  <= POS_W'(rd_cnt);
      last_q <= final_rd;
      resp_q <= resp_frame;
    end
  end

  assign busy               = active;
  assign out_ch.valid       = out_valid;
  assign out_ch.frame_byte  = rdata;
  assign out_ch.byte_pos    = pos_q;
  assign out_ch.is_response = resp_q;
  assign out_ch.last        = last_q;

endmodule

>>> src/serial_telegram_deframer.sv
// Each received byte is taken as its beat is accepted; accepting the terminator of a
// good telegram sets the emitter active, and the first read loads its first byte for output.
// Throughput: one received byte per cycle while parsing; a telegram is then read from
// the frame buffer at one byte per cycle while the output is not stalled, and input is
// held off until its last byte has been read from the buffer, output stalls included.
// Reset (rst, synchronous) returns the parser to sync hunting with an empty buffer and
// loads the configuration registers with their defaults; buffer contents are not cleared.
module serial_telegram_deframer import stdf_pkg::*; #(
  parameter int FRAME_DEPTH = 64,
  parameter int LENGTH_POS  = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  stdf_in_if.sink               in_ch,
  stdf_out_if.source            out_ch
);

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int CW = $clog2(FRAME_DEPTH + 1);
  localparam int EW = ((CW > LIMIT_W) ? CW : LIMIT_W) + 2;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_START  = 2'd1;
  localparam logic [1:0] PH_PDU    = 2'd2;
  localparam logic [1:0] PH_FOOTER = 2'd3;

  logic [BYTE_W-1:0]  first_byte_resp;
  logic [BYTE_W-1:0]  first_byte_req;
  logic [BYTE_W-1:0]  second_byte_resp;
  logic [BYTE_W-1:0]  second_byte_req;
  logic [BYTE_W-1:0]  end_marker;
  logic [LIMIT_W-1:0] payload_limit;

  logic [1:0]         phase, phase_next;
  logic [CW-1:0]      fill, fill_next;
  logic [LIMIT_W-1:0] len_q, len_q_next;
  logic [BYTE_W-1:0]  acc, acc_next;
  logic [BYTE_W-1:0]  last_b, last_b_next;
  logic [BYTE_W-1:0]  byte0, byte0_next;

  logic               busy;
  logic               in_fire;
  logic [BYTE_W-1:0]  b;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  stdf_emit_t         emit_ctl;
  logic [CW-1:0]      emit_count;
  logic [EW-1:0]      fill_e;
  logic [EW-1:0]      pdu_end;

  assign in_ch.ready = !busy;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign fill_e      = EW'(fill);
  assign pdu_end     = EW'(LENGTH_POS) + EW'(len_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_byte_resp  <= '0;
      first_byte_req   <= '0;
      second_byte_resp <= '0;
      second_byte_req  <= '0;
      end_marker       <= '0;
      payload_limit    <= PAYLOAD_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_RESP:  first_byte_resp  <= cfg_data;
        CFG_FIRST_REQ:   first_byte_req   <= cfg_data;
        CFG_SECOND_RESP: second_byte_resp <= cfg_data;
        CFG_SECOND_REQ:  second_byte_req  <= cfg_data;
        CFG_END_MARKER:  end_marker       <= cfg_data;
        CFG_PAYLOAD_LIM: payload_limit    <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next     = phase;
    fill_next      = fill;
    len_q_next     = len_q;
    acc_next       = acc;
    last_b_next    = last_b;
    byte0_next     = byte0;
    wr_en          = 1'b0;
    wr_addr        = fill[AW-1:0];
    emit_ctl.start = 1'b0;
    emit_ctl.resp  = (byte0 == first_byte_resp);
    emit_count     = CW'(fill + 1'b1);

    if (in_fire) begin
      if (in_ch.clear) begin
        phase_next = PH_IDLE;
        fill_next  = '0;
      end else if (phase == PH_IDLE) begin
        if (fill == '0 && (b == first_byte_resp || b == first_byte_req)) begin
          wr_en      = 1'b1;
          byte0_next = b;
          fill_next  = CW'(1);
        end else if (fill == CW'(1) && (b == second_byte_resp || b == second_byte_req)) begin
          wr_en      = 1'b1;
          fill_next  = CW'(2);
          phase_next = PH_START;
        end else begin
          fill_next = '0;
        end
      end else if (fill_e >= EW'(FRAME_DEPTH)) begin
        phase_next = PH_IDLE;
        fill_next  = '0;
      end else begin
        wr_en     = 1'b1;
        fill_next = CW'(fill + 1'b1);
        // acc holds the length byte XOR the payload bytes up to two places back;
        // last_b holds the previous byte, the checksum candidate.
        if (fill_e == EW'(LENGTH_POS)) begin
          acc_next    = b;
          last_b_next = b;
        end else if (fill_e > EW'(LENGTH_POS)) begin
          if (fill_e >= EW'(LENGTH_POS + 2)) begin
            acc_next = acc ^ last_b;
          end
          last_b_next = b;
        end

        case (phase)
          PH_START: begin
            if (fill_e == EW'(LENGTH_POS)) begin
              len_q_next = b[LIMIT_W-1:0];
              if (b > BYTE_W'(payload_limit)) begin
                phase_next = PH_IDLE;
                fill_next  = '0;
              end else if (b == '0) begin
                phase_next = PH_FOOTER;
              end else begin
                phase_next = PH_PDU;
              end
            end
          end
          PH_PDU: begin
            if (fill_e == pdu_end) begin
              phase_next = PH_FOOTER;
            end
          end
          default: begin
            if (b == end_marker) begin
              emit_ctl.start = (acc == last_b);
              phase_next     = PH_IDLE;
              fill_next      = '0;
            end else if (fill_e > EW'(pdu_end + 1'b1)) begin
              phase_next = PH_IDLE;
              fill_next  = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      fill  <= '0;
    end else begin
      phase <= phase_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    len_q  <= len_q_next;
    acc    <= acc_next;
    last_b <= last_b_next;
    byte0  <= byte0_next;
  end

  stdf_emitter #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_emitter (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (b),
    .ctl     (emit_ctl),
    .count   (emit_count),
    .busy    (busy),
    .out_ch  (out_ch)
  );

  // The buffer is never written while a telegram is being read out of it.
  a_no_write_during_readout: assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr_en)
    else $error("frame buffer written during readout");

  a_start_blocks_input: assert property (@(posedge clk) disable iff (rst)
    emit_ctl.start |=> !in_ch.ready)
    else $error("input taken right after a telegram was released");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_e <= EW'(FRAME_DEPTH))
    else $error("fill count beyond buffer depth");

  a_idle_fill: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> fill <= CW'(1))
    else $error("sync hunting with more than one stored byte");

  a_start_in_footer: assert property (@(posedge clk) disable iff (rst)
    emit_ctl.start |-> phase == PH_FOOTER && !in_ch.clear)
    else $error("telegram released outside the footer");

endmodule
